// ===== sv/sca_pkg.sv =====
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types, constants and helpers for the segment checker and reply former
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int unsigned HdrBytes = 6;

  typedef enum logic {
    CMD_SEGMENT = 1'b0,
    CMD_RESEND  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    RT_NONE = 2'd0,
    RT_ACK  = 2'd1,
    RT_SYN  = 2'd2,
    RT_FIN  = 2'd3
  } reply_type_e;

  typedef enum logic [2:0] {
    ST_ACK     = 3'd0,
    ST_FIN     = 3'd1,
    ST_SYN     = 3'd2,
    ST_NO_FLAG = 3'd3,
    ST_SHORT   = 3'd4,
    ST_BAD_SUM = 3'd5
  } status_e;

  localparam logic [1:0] CFG_ACK_MASK = 2'd0;
  localparam logic [1:0] CFG_FIN_MASK = 2'd1;
  localparam logic [1:0] CFG_SYN_MASK = 2'd2;

  typedef struct packed {
    logic [15:0] ack_mask;
    logic [15:0] fin_mask;
    logic [15:0] syn_mask;
  } cfg_t;

  // segment state as it stands after the current byte
  typedef struct packed {
    logic [15:0] count;
    logic [15:0] sum;
    logic [15:0] hdr_seq;
    logic [15:0] hdr_flags;
    logic [15:0] hdr_chk;
  } seg_info_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [15:0] seg_seq;
    logic        seq_match;
    logic [15:0] seg_len;
    logic [15:0] rep_seq;
    logic [15:0] rep_flags;
    logic [15:0] rep_chk;
    logic        rep_valid;
  } result_t;

  // 16-bit ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    oc_add = s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== sv/sca_accum.sv =====
// ----------------------------------------------------------------------------
// sca_accum
// Byte counter, header capture and running ones-complement sum of a segment
// ----------------------------------------------------------------------------
module sca_accum import sca_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      go_i,
  input  logic [7:0] data_byte_i,
  input  logic      last_i,
  output seg_info_t info_o
);

  logic [15:0] cnt_q, sum_q, hseq_q, hflags_q, hchk_q;
  logic [15:0] hseq_d, hflags_d, hchk_d, cnt_d, sum_w, word;
  logic [7:0]  pend_q, sb;
  logic        odd_q, in_hdr;

  assign in_hdr = cnt_q < 16'(HdrBytes);

  always_comb begin
    hseq_d   = hseq_q;
    hflags_d = hflags_q;
    hchk_d   = hchk_q;
    sb       = data_byte_i;
    if (in_hdr) begin
      case (cnt_q[2:0])
        3'd0: begin
          hseq_d   = {data_byte_i, 8'h00};
          hflags_d = '0;
          hchk_d   = '0;
        end
        3'd1: hseq_d = {hseq_q[15:8], data_byte_i};
        3'd2: hflags_d = {data_byte_i, 8'h00};
        3'd3: hflags_d = {hflags_q[15:8], data_byte_i};
        3'd4: begin
          hchk_d = {data_byte_i, 8'h00};
          sb     = '0;
        end
        3'd5: begin
          hchk_d = {hchk_q[15:8], data_byte_i};
          sb     = '0;
        end
        default: ;
      endcase
    end
    // odd final byte is padded into the high half
    word  = odd_q ? {pend_q, sb} : {sb, 8'h00};
    sum_w = oc_add(sum_q, word);
    cnt_d = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      pend_q   <= '0;
      odd_q    <= 1'b0;
      hseq_q   <= '0;
      hflags_q <= '0;
      hchk_q   <= '0;
    end else if (go_i) begin
      hseq_q   <= hseq_d;
      hflags_q <= hflags_d;
      hchk_q   <= hchk_d;
      if (last_i) begin
        cnt_q  <= '0;
        sum_q  <= '0;
        pend_q <= '0;
        odd_q  <= 1'b0;
      end else begin
        cnt_q <= cnt_d;
        if (odd_q) begin
          sum_q  <= sum_w;
          pend_q <= '0;
          odd_q  <= 1'b0;
        end else begin
          pend_q <= sb;
          odd_q  <= 1'b1;
        end
      end
    end
  end

  assign info_o = '{count: cnt_d, sum: sum_w, hdr_seq: hseq_d,
                    hdr_flags: hflags_d, hdr_chk: hchk_d};

endmodule

// ===== sv/sca_verdict.sv =====
// ----------------------------------------------------------------------------
// sca_verdict
// Segment status, expected sequence tracking and reply forming and storage
// ----------------------------------------------------------------------------
module sca_verdict import sca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        upd_i,
  input  cmd_e        cmd_i,
  input  reply_type_e reply_type_i,
  input  logic        set_expected_i,
  input  seg_info_t   info_i,
  input  cfg_t        cfg_i,
  output result_t     res_o
);

  logic [15:0] exp_q, exp_eff, rseq, rflags, rchk, adv;
  logic [47:0] stored_q;
  logic        stored_valid_q, accepted, form;
  status_e     status;

  always_comb begin
    if (info_i.count < 16'(HdrBytes)) begin
      status = ST_SHORT;
    end else if (~info_i.sum != info_i.hdr_chk) begin
      status = ST_BAD_SUM;
    end else if ((info_i.hdr_flags & cfg_i.ack_mask) != '0) begin
      status = ST_ACK;
    end else if ((info_i.hdr_flags & cfg_i.fin_mask) != '0) begin
      status = ST_FIN;
    end else if ((info_i.hdr_flags & cfg_i.syn_mask) != '0) begin
      status = ST_SYN;
    end else begin
      status = ST_NO_FLAG;
    end
  end

  assign accepted = (status != ST_SHORT) && (status != ST_BAD_SUM);
  assign form     = accepted && (reply_type_i != RT_NONE);
  assign exp_eff  = (accepted && set_expected_i) ? info_i.hdr_seq : exp_q;
  assign adv      = (info_i.count == 16'(HdrBytes)) ? 16'd1 : info_i.count - 16'(HdrBytes);
  assign rseq     = exp_eff + adv;

  always_comb begin
    case (reply_type_i)
      RT_ACK:  rflags = cfg_i.ack_mask;
      RT_SYN:  rflags = cfg_i.syn_mask;
      default: rflags = cfg_i.fin_mask;
    endcase
  end

  assign rchk = ~oc_add(rseq, rflags);

  always_comb begin
    res_o = '0;
    if (cmd_i == CMD_RESEND) begin
      res_o.kind = 1'b1;
      if (stored_valid_q) begin
        res_o.rep_seq   = stored_q[47:32];
        res_o.rep_flags = stored_q[31:16];
        res_o.rep_chk   = stored_q[15:0];
        res_o.rep_valid = 1'b1;
      end
    end else begin
      res_o.status    = status;
      res_o.seg_seq   = info_i.hdr_seq;
      res_o.seq_match = info_i.hdr_seq == exp_q;
      res_o.seg_len   = info_i.count;
      if (form) begin
        res_o.rep_seq   = rseq;
        res_o.rep_flags = rflags;
        res_o.rep_chk   = rchk;
        res_o.rep_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q          <= '0;
      stored_q       <= '0;
      stored_valid_q <= 1'b0;
    end else if (upd_i) begin
      exp_q <= exp_eff;
      if (form) begin
        stored_q       <= {rseq, rflags, rchk};
        stored_valid_q <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/segment_check_and_ack_former.sv =====
// ----------------------------------------------------------------------------
// segment_check_and_ack_former
// Checks a byte-serial segment and forms, stores and resends a 6-byte reply
// ----------------------------------------------------------------------------
// Takes one segment byte or resend command per cycle while the input side
// is not stalled. Each accepted transaction is held in an input register,
// then a single pass of logic updates the segment state and fills the
// result register, so a result passes the input register and then the
// result register. The input side stalls only while a result is waiting
// to be taken and the next transaction would produce another one. A result
// is produced on the last byte of a segment and on every resend; other bytes give none.
// Configuration writes must be made only while idle; the block does not check.
module segment_check_and_ack_former import sca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic [1:0]  reply_type_i,
  input  logic        set_expected_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [2:0]  status_o,
  output logic [15:0] segment_sequence_o,
  output logic        sequence_matches_o,
  output logic [15:0] segment_length_o,
  output logic [15:0] reply_sequence_o,
  output logic [15:0] reply_flags_o,
  output logic [15:0] reply_checksum_o,
  output logic        reply_valid_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t        cfg_q;
  logic        in_valid_q, cmd_q, last_q, set_exp_q;
  logic [7:0]  data_q;
  logic [1:0]  rtype_q;
  logic        out_valid_q, has_result, out_free, go, go_seg;
  seg_info_t   info;
  result_t     res, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ack_mask: 16'd1, fin_mask: 16'd2, syn_mask: 16'd4};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ACK_MASK: cfg_q.ack_mask <= cfg_data_i;
        CFG_FIN_MASK: cfg_q.fin_mask <= cfg_data_i;
        CFG_SYN_MASK: cfg_q.syn_mask <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  assign has_result = (cmd_q == CMD_RESEND) || last_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign go         = in_valid_q && (!has_result || out_free);
  assign go_seg     = go && (cmd_q == CMD_SEGMENT);
  assign in_stall_o = in_valid_q && !go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q     <= cmd_i;
      data_q    <= data_byte_i;
      last_q    <= last_i;
      rtype_q   <= reply_type_i;
      set_exp_q <= set_expected_i;
    end
  end

  sca_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go_seg),
    .data_byte_i (data_q),
    .last_i      (last_q),
    .info_o      (info)
  );

  sca_verdict u_verdict (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_i          (go_seg && last_q),
    .cmd_i          (cmd_e'(cmd_q)),
    .reply_type_i   (reply_type_e'(rtype_q)),
    .set_expected_i (set_exp_q),
    .info_i         (info),
    .cfg_i          (cfg_q),
    .res_o          (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && has_result) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = res_q.kind;
  assign status_o           = res_q.status;
  assign segment_sequence_o = res_q.seg_seq;
  assign sequence_matches_o = res_q.seq_match;
  assign segment_length_o   = res_q.seg_len;
  assign reply_sequence_o   = res_q.rep_seq;
  assign reply_flags_o      = res_q.rep_flags;
  assign reply_checksum_o   = res_q.rep_chk;
  assign reply_valid_o      = res_q.rep_valid;

endmodule

// ===== sv/sca_checker.sv =====
// ----------------------------------------------------------------------------
// sca_checker
// Port-level checks on the result channel of the segment checker
// ----------------------------------------------------------------------------
module sca_checker import sca_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic        kind_i,
  input logic [2:0]  status_i,
  input logic [15:0] segment_length_i,
  input logic [15:0] reply_sequence_i,
  input logic [15:0] reply_flags_i,
  input logic [15:0] reply_checksum_i,
  input logic        reply_valid_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(reply_sequence_i)
      && $stable(status_i) && $stable(kind_i))
    else $error("result changed while stalled");

  a_no_reply_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !reply_valid_i |-> reply_sequence_i == '0 && reply_flags_i == '0
      && reply_checksum_i == '0)
    else $error("reply fields set without a reply");

  a_reply_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && reply_valid_i |->
      reply_checksum_i == ~oc_add(reply_sequence_i, reply_flags_i))
    else $error("reply checksum inconsistent");

  a_reply_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !kind_i && reply_valid_i |->
      status_i != ST_SHORT && status_i != ST_BAD_SUM)
    else $error("reply formed for a rejected segment");

  a_length_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !kind_i |->
      (segment_length_i < 16'(HdrBytes)) == (status_i == ST_SHORT))
    else $error("length and short status disagree");

endmodule

bind segment_check_and_ack_former sca_checker u_sca_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kind_i           (kind_o),
  .status_i         (status_o),
  .segment_length_i (segment_length_o),
  .reply_sequence_i (reply_sequence_o),
  .reply_flags_i    (reply_flags_o),
  .reply_checksum_i (reply_checksum_o),
  .reply_valid_i    (reply_valid_o)
);
